// File: design/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the scope capture and trigger search block.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int DEPTH_DEF        = 2048;
    localparam int SCREEN_WIDTH_DEF = 128;

    localparam int OPCODE_W   = 2;
    localparam int SAMPLE_W   = 12;
    localparam int OFFSET_W   = 7;
    localparam int TIDX_W     = 11;
    localparam int ERR_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // command opcodes
    localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_FALLING  = 1'd1;

    localparam logic [SAMPLE_W-1:0] TRIGGER_LEVEL_RESET = 12'd2048;
    localparam logic                EDGE_FALLING_RESET  = 1'b0;

    // result kinds
    localparam logic RK_TRIGGER = 1'b0;
    localparam logic RK_SAMPLE  = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SAMPLE_W-1:0] sample_value;
        logic                overflow_seen;
        logic [OFFSET_W-1:0] read_offset;
    } in_t;

    typedef struct packed {
        logic                result_kind;
        logic [TIDX_W-1:0]   trigger_index;
        logic                trigger_found;
        logic [ERR_W-1:0]    error_count;
        logic [SAMPLE_W-1:0] read_sample;
    } out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] trigger_level;
        logic                edge_falling;
    } cfg_t;

    typedef enum logic [1:0] {
        K_STORE  = 2'd0,
        K_SEARCH = 2'd1,
        K_READ   = 2'd2
    } cmd_kind_t;

    // decoded command as it waits in the queue
    typedef struct packed {
        cmd_kind_t           kind;
        logic [SAMPLE_W-1:0] sample;
        logic                ovf;
        logic [OFFSET_W-1:0] offset;
    } qcmd_t;

endpackage
`default_nettype wire

// File: design/sct_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: design/sct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front
// Accepts command beats, decodes the opcode and queues the decoded command.
// ----------------------------------------------------------------------------
module sct_front
    import sct_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire in_t   cmd,
    output logic       busy,
    output logic       q_valid,
    output qcmd_t      q_head,
    input  wire logic  q_pop
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    qcmd_t             q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic  accept;
    logic  push;
    qcmd_t decoded;

    assign busy   = (count_reg == QCNT_W'(QDEPTH));
    assign accept = start && !busy;

    always_comb
    begin
        decoded.sample = cmd.sample_value;
        decoded.ovf    = cmd.overflow_seen;
        decoded.offset = cmd.read_offset;
        decoded.kind   = K_STORE;
        push           = accept;
        unique case (cmd.opcode)
            OP_STORE:  decoded.kind = K_STORE;
            OP_SEARCH: decoded.kind = K_SEARCH;
            OP_READ:   decoded.kind = K_READ;
            default:   push = 1'b0; // unused opcode is taken and dropped
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= decoded;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_head  = q_mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// File: design/sct_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back
// Executes queued commands against the capture ring: stores, edge search
// walking backward one ring entry per cycle, and windowed readout.
// ----------------------------------------------------------------------------
module sct_back
    import sct_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire qcmd_t q_head,
    output logic       q_pop,
    output logic       result_valid,
    output out_t       result
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] HALF_BACK   = AW'((SCREEN_WIDTH / 2) % DEPTH);
    localparam logic [AW-1:0] SCREEN_BACK = AW'(SCREEN_WIDTH % DEPTH);
    localparam logic [AW-1:0] LAST_POS    = AW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_STEP   = AW'(DEPTH / 2 - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_READ   = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic [ERR_W-1:0]   ovf_cnt_reg, ovf_cnt_next;
    logic [AW-1:0]      last_trig_reg, last_trig_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      start_reg, start_next;
    logic [AW-1:0]      issue_reg, issue_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] cur_reg, cur_next;
    logic               have_cur_reg, have_cur_next;
    logic               result_valid_reg, result_valid_next;
    out_t               result_reg, result_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic [AW-1:0] wp_inc;
    logic [AW-1:0] search_start;
    logic [AW-1:0] win_base;
    logic [AW:0]   win_sum;
    logic [AW-1:0] read_idx;
    logic          hit;

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
        ring_dec = (x == '0) ? LAST_POS : x - 1'b1;
    endfunction

    assign wp_inc       = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
    // newest position minus half the screen, modulo the ring depth
    assign search_start = (wp_reg >= HALF_BACK) ? wp_reg - HALF_BACK
                                                : wp_reg + AW'(DEPTH) - HALF_BACK;
    assign win_base     = (last_trig_reg >= SCREEN_BACK) ? last_trig_reg - SCREEN_BACK
                                                         : last_trig_reg + AW'(DEPTH) - SCREEN_BACK;
    assign win_sum      = {1'b0, win_base} + (AW + 1)'(q_head.offset);
    assign read_idx     = (win_sum >= (AW + 1)'(DEPTH)) ? AW'(win_sum - (AW + 1)'(DEPTH))
                                                        : win_sum[AW-1:0];

    // cur_reg holds ring[pos], read data holds ring[pos - 1]
    assign hit = cfg.edge_falling
               ? (cur_reg <  cfg.trigger_level) && (ram_rdata >= cfg.trigger_level)
               : (cur_reg >= cfg.trigger_level) && (ram_rdata <  cfg.trigger_level);

    assign q_pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next        = state_reg;
        wp_next           = wp_reg;
        ovf_cnt_next      = ovf_cnt_reg;
        last_trig_next    = last_trig_reg;
        pos_next          = pos_reg;
        start_next        = start_reg;
        issue_next        = issue_reg;
        cnt_next          = cnt_reg;
        cur_next          = cur_reg;
        have_cur_next     = have_cur_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = wp_inc;
        ram_raddr         = issue_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_head.kind)
                        K_STORE:
                        begin
                            ram_we       = 1'b1;
                            wp_next      = wp_inc;
                            ovf_cnt_next = ovf_cnt_reg + ERR_W'(q_head.ovf);
                        end
                        K_SEARCH:
                        begin
                            ram_raddr     = search_start;
                            start_next    = search_start;
                            pos_next      = search_start;
                            issue_next    = ring_dec(search_start);
                            cnt_next      = '0;
                            have_cur_next = 1'b0;
                            state_next    = ST_SEARCH;
                        end
                        K_READ:
                        begin
                            ram_raddr  = read_idx;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                issue_next = ring_dec(issue_reg);
                if (!have_cur_reg)
                begin
                    cur_next      = ram_rdata;
                    have_cur_next = 1'b1;
                end
                else if (hit || (cnt_reg == LAST_STEP))
                begin
                    last_trig_next              = hit ? pos_reg : start_reg;
                    result_valid_next           = 1'b1;
                    result_next.result_kind     = RK_TRIGGER;
                    result_next.trigger_index   = TIDX_W'(hit ? pos_reg : start_reg);
                    result_next.trigger_found   = hit;
                    result_next.error_count     = ovf_cnt_reg;
                    result_next.read_sample     = '0;
                    state_next                  = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    pos_next = ring_dec(pos_reg);
                    cur_next = ram_rdata;
                end
            end

            ST_READ:
            begin
                result_valid_next           = 1'b1;
                result_next.result_kind     = RK_SAMPLE;
                result_next.trigger_index   = TIDX_W'(last_trig_reg);
                result_next.trigger_found   = 1'b0;
                result_next.error_count     = ovf_cnt_reg;
                result_next.read_sample     = ram_rdata;
                state_next                  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= LAST_POS;
            ovf_cnt_reg      <= '0;
            last_trig_reg    <= '0;
            have_cur_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            wp_reg           <= wp_next;
            ovf_cnt_reg      <= ovf_cnt_next;
            last_trig_reg    <= last_trig_next;
            have_cur_reg     <= have_cur_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        start_reg  <= start_next;
        issue_reg  <= issue_next;
        cnt_reg    <= cnt_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    sct_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_head.sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// File: design/scope_capture_trigger_search.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_capture_trigger_search
// Capture ring with overflow counting, edge trigger search and windowed
// sample readout for a sampling oscilloscope.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low.
//   cmd.opcode selects store sample, search trigger or read captured sample;
//   opcode three is taken and dropped.
//   Commands pass through a two-entry queue to the execution side, so busy
//   rises only while that side is held up by a search or a read.
//   Store: taken from the queue in the idle state, no result; one store a
//   cycle can be sustained.
//   Read: result_valid pulses with the beat once the command has passed the
//   queue, the registered ring read and the result register.
//   Search: walks the ring backward one entry a cycle through the single
//   ring read port; a hit reports its position, a miss reports the search
//   start with trigger_found low after DEPTH/2 positions.
//   Results hold for exactly one cycle on result_valid; there is no back
//   pressure, so the receiver must take every beat.
//   Reset clears the queue, write position (DEPTH - 1), error count, trigger
//   point and configuration; ring contents stay undefined until written.
//   Configuration writes via cfg_we / cfg_index / cfg_data are registered before they take effect.
// ----------------------------------------------------------------------------
module scope_capture_trigger_search
    import sct_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_t                   cmd,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    output out_t                       result
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_valid;
    qcmd_t q_head;
    logic  q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_LEVEL: cfg_next.trigger_level = cfg_data[SAMPLE_W-1:0];
                CFG_EDGE_FALLING:  cfg_next.edge_falling  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level <= TRIGGER_LEVEL_RESET;
            cfg_reg.edge_falling  <= EDGE_FALLING_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    sct_back #(
        .DEPTH        (DEPTH),
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// File: design/sct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks on the result beats of the trigger search block.
// ----------------------------------------------------------------------------
module sct_checker
    import sct_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic result_valid,
    input wire out_t result
);

    // every command that reports passes through the idle state first
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beats on consecutive cycles");

    a_search_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind == RK_TRIGGER)) |-> (result.read_sample == '0))
        else $error("trigger report carries a sample");

    a_read_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.result_kind == RK_SAMPLE)) |-> !result.trigger_found)
        else $error("sample readout flags a found trigger");

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> (!busy && !result_valid))
        else $error("busy or result beat right after reset");

    // an accepted beat cannot fill the queue by itself
    a_single_accept_no_full: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(!busy) && !busy && $past(start) && !start) |=> !busy)
        else $error("queue reported full after a lone beat");

endmodule

bind scope_capture_trigger_search sct_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire
